>>> hw/rtl/lkq_pkg.sv
package lkq_pkg;

	localparam int KIND_W   = 2;
	localparam int LOCK_W   = 6;
	localparam int CLIENT_W = 8;
	localparam int STATUS_W = 2;
	localparam int MSG_W    = 2;
	localparam int COUNT_W  = 7;

	localparam int DEF_NUM_LOCKS   = 64;
	localparam int DEF_QUEUE_DEPTH = 8;
	localparam int DEF_CLIENT_BITS = 8;

	typedef enum logic [KIND_W-1:0] {
		KIND_ACQUIRE = 2'd0,
		KIND_RELEASE = 2'd1,
		KIND_STAT    = 2'd2
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 2'd0,
		ST_RETRY      = 2'd1,
		ST_QUEUE_FULL = 2'd2
	} status_t;

	typedef enum logic [MSG_W-1:0] {
		MSG_NONE   = 2'd0,
		MSG_REVOKE = 2'd1,
		MSG_RETRY  = 2'd2
	} msg_t;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_LOOK = 3'b010,
		S_UPD  = 3'b100
	} state_t;

endpackage

>>> hw/rtl/lkq_if.sv
interface lkq_req_if import lkq_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [LOCK_W-1:0]   lock_id;
	logic [CLIENT_W-1:0] client_id;

	modport source (output valid, kind, lock_id, client_id, input ready);
	modport sink (input valid, kind, lock_id, client_id, output ready);
endinterface

interface lkq_rsp_if import lkq_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [MSG_W-1:0]    message_kind;
	logic [CLIENT_W-1:0] message_target;
	logic [LOCK_W-1:0]   message_lock;
	logic [COUNT_W-1:0]  held_count;

	modport source (output valid, status, message_kind, message_target, message_lock,
		held_count, input ready);
	modport sink (input valid, status, message_kind, message_target, message_lock,
		held_count, output ready);
endinterface

>>> hw/rtl/lkq_ram.sv
module lkq_ram import lkq_pkg::*; #(
	parameter int WIDTH = DEF_CLIENT_BITS,
	parameter int DEPTH = DEF_NUM_LOCKS * DEF_QUEUE_DEPTH,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hw/rtl/lkq_lock_table.sv
module lkq_lock_table import lkq_pkg::*; #(
	parameter int ENT_W = 16,
	parameter int DEPTH = DEF_NUM_LOCKS,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [ENT_W-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [ENT_W-1:0] rdata
);

	// An entry never written reads as all zero: free lock, empty queue.
	logic [DEPTH-1:0] vld_q;
	logic             rd_vld_q;
	logic [ENT_W-1:0] ram_rdata;

	lkq_ram #(
		.WIDTH(ENT_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (re) begin
				rd_vld_q <= vld_q[raddr];
			end
		end
	end

	assign rdata = rd_vld_q ? ram_rdata : '0;

endmodule

>>> hw/rtl/lock_table_with_waiter_queues.sv
// Lock table with a FIFO of waiting clients per lock. Each request transaction
// produces exactly one response transaction. The accept cycle reads the lock
// entry memory; the look state reads the waiter memory at a slot that depends on
// that entry and writes a queued acquirer at the tail; the update state writes
// the lock entry back and loads the response register once that register is
// free. A new request is accepted in the cycle after the response is loaded,
// even while that response still waits to be taken. No clearing pass follows
// reset: per-lock valid bits make every lock read as free and unqueued.
module lock_table_with_waiter_queues import lkq_pkg::*; #(
	parameter int NUM_LOCKS   = DEF_NUM_LOCKS,
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
	parameter int CLIENT_BITS = DEF_CLIENT_BITS
) (
	input logic clk,
	input logic arst_n,
	lkq_req_if.sink   req,
	lkq_rsp_if.source rsp
);

	localparam int LOCK_SPAN    = 2 ** LOCK_W;
	localparam int LOCK_ENTRIES = (NUM_LOCKS < LOCK_SPAN) ? NUM_LOCKS : LOCK_SPAN;
	localparam int LK_W         = $clog2(LOCK_ENTRIES);
	localparam int QP_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QC_W         = $clog2(QUEUE_DEPTH + 1);
	localparam int PS_W         = QC_W + 1;
	localparam int SLOTS        = LOCK_ENTRIES * QUEUE_DEPTH;
	localparam int SLOT_W       = $clog2(SLOTS);
	localparam int ENT_W        = 1 + CLIENT_BITS + QP_W + QC_W;

	typedef logic [LK_W-1:0] lk_map_t [LOCK_SPAN];

	function automatic lk_map_t build_lk_map();
		lk_map_t m;
		for (int i = 0; i < LOCK_SPAN; i++) begin
			m[i] = LK_W'(i % NUM_LOCKS);
		end
		return m;
	endfunction

	localparam lk_map_t LK_MAP = build_lk_map();

	typedef struct packed {
		logic                   held;
		logic [CLIENT_BITS-1:0] owner;
		logic [QP_W-1:0]        head;
		logic [QC_W-1:0]        count;
	} entry_t;

	state_t                 state_q;
	logic [KIND_W-1:0]      kind_q;
	logic [LK_W-1:0]        lk_q;
	logic [CLIENT_BITS-1:0] cl_q;
	logic [COUNT_W-1:0]     total_q;

	logic                   out_valid_q;
	logic [STATUS_W-1:0]    status_q;
	logic [MSG_W-1:0]       msg_kind_q;
	logic [CLIENT_W-1:0]    msg_target_q;
	logic [LOCK_W-1:0]      msg_lock_q;
	logic [COUNT_W-1:0]     held_count_q;

	logic                   in_fire;
	logic                   upd_go;
	logic [LK_W-1:0]        lk_in;
	logic [ENT_W-1:0]       ent_rdata;
	entry_t                 ent;
	entry_t                 ent_new;
	logic                   ent_we;

	logic [PS_W-1:0]        pos_sum;
	logic [PS_W-1:0]        pos_last;
	logic [PS_W-1:0]        head_inc;
	logic [QP_W-1:0]        tail_pos;
	logic [QP_W-1:0]        newest_pos;
	logic [QP_W-1:0]        next_head;
	logic [QP_W-1:0]        rd_pos;
	logic [SLOT_W-1:0]      slot_base;
	logic                   wt_we;
	logic [CLIENT_BITS-1:0] wt_rdata;
	logic                   q_full;

	logic [STATUS_W-1:0]    status_d;
	logic [MSG_W-1:0]       msg_kind_d;
	logic [CLIENT_BITS-1:0] msg_target_d;
	logic                   msg_lock_en;
	logic [COUNT_W-1:0]     held_count_d;
	logic [COUNT_W-1:0]     total_d;

	assign req.ready = (state_q == S_IDLE);
	assign in_fire   = req.valid && req.ready;
	assign upd_go    = (state_q == S_UPD) && (!out_valid_q || rsp.ready);
	assign lk_in     = LK_MAP[req.lock_id];

	assign ent    = entry_t'(ent_rdata);
	assign q_full = (ent.count >= QC_W'(QUEUE_DEPTH));

	assign pos_sum    = PS_W'(ent.head) + PS_W'(ent.count);
	assign pos_last   = pos_sum - PS_W'(1);
	assign head_inc   = PS_W'(ent.head) + PS_W'(1);
	assign tail_pos   = QP_W'((pos_sum >= PS_W'(QUEUE_DEPTH)) ?
		pos_sum - PS_W'(QUEUE_DEPTH) : pos_sum);
	assign newest_pos = QP_W'((pos_last >= PS_W'(QUEUE_DEPTH)) ?
		pos_last - PS_W'(QUEUE_DEPTH) : pos_last);
	assign next_head  = QP_W'((head_inc >= PS_W'(QUEUE_DEPTH)) ?
		head_inc - PS_W'(QUEUE_DEPTH) : head_inc);
	assign rd_pos     = (kind_q == KIND_ACQUIRE) ? newest_pos : ent.head;
	assign slot_base  = SLOT_W'(lk_q) * SLOT_W'(QUEUE_DEPTH);

	assign wt_we = (state_q == S_LOOK) && (kind_q == KIND_ACQUIRE) && ent.held && !q_full;

	lkq_lock_table #(
		.ENT_W(ENT_W),
		.DEPTH(LOCK_ENTRIES)
	) u_lock_table (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (ent_we),
		.waddr (lk_q),
		.wdata (ent_new),
		.re    (in_fire),
		.raddr (lk_in),
		.rdata (ent_rdata)
	);

	lkq_ram #(
		.WIDTH(CLIENT_BITS),
		.DEPTH(SLOTS)
	) u_waiter_ram (
		.clk  (clk),
		.we   (wt_we),
		.waddr(slot_base + SLOT_W'(tail_pos)),
		.wdata(cl_q),
		.re   (state_q == S_LOOK),
		.raddr(slot_base + SLOT_W'(rd_pos)),
		.rdata(wt_rdata)
	);

	always_comb begin
		ent_new      = ent;
		ent_we       = 1'b0;
		status_d     = ST_OK;
		msg_kind_d   = MSG_NONE;
		msg_target_d = '0;
		msg_lock_en  = 1'b0;
		held_count_d = '0;
		total_d      = total_q;
		case (kind_q)
			KIND_ACQUIRE: begin
				ent_we = upd_go;
				if (!ent.held) begin
					ent_new.held  = 1'b1;
					ent_new.owner = cl_q;
					total_d       = total_q + COUNT_W'(1);
				end else if (q_full) begin
					status_d = ST_QUEUE_FULL;
				end else begin
					ent_new.count = ent.count + QC_W'(1);
					status_d      = ST_RETRY;
					msg_kind_d    = MSG_REVOKE;
					msg_target_d  = (ent.count != '0) ? wt_rdata : ent.owner;
					msg_lock_en   = 1'b1;
				end
			end
			KIND_RELEASE: begin
				ent_we = upd_go;
				if (ent.count != '0) begin
					ent_new.head  = next_head;
					ent_new.count = ent.count - QC_W'(1);
					ent_new.owner = wt_rdata;
					ent_new.held  = 1'b1;
					msg_kind_d    = MSG_RETRY;
					msg_target_d  = wt_rdata;
					msg_lock_en   = 1'b1;
				end else begin
					ent_new.held = 1'b0;
					if (ent.held && (total_q != '0)) begin
						total_d = total_q - COUNT_W'(1);
					end
				end
			end
			default: begin
				held_count_d = total_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					if (upd_go) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (upd_go) begin
				total_q     <= total_d;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_q <= req.kind;
			lk_q   <= lk_in;
			cl_q   <= CLIENT_BITS'(req.client_id);
		end
		if (upd_go) begin
			status_q     <= status_d;
			msg_kind_q   <= msg_kind_d;
			msg_target_q <= CLIENT_W'(msg_target_d);
			msg_lock_q   <= msg_lock_en ? LOCK_W'(lk_q) : '0;
			held_count_q <= held_count_d;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.status         = status_q;
	assign rsp.message_kind   = msg_kind_q;
	assign rsp.message_target = msg_target_q;
	assign rsp.message_lock   = msg_lock_q;
	assign rsp.held_count     = held_count_q;

endmodule
